// ----- rtl/core/xcfd_pkg.sv -----
// Shared types and constants for the XOR-checked frame deframer.
`default_nettype none

package xcfd_pkg;

  // Parser phases; PH_DRAIN plays the stored payload out of the buffer
  typedef enum logic [2:0] {
    PH_HDR1,
    PH_HDR2,
    PH_TOPIC,
    PH_LEN,
    PH_DATA,
    PH_SUM,
    PH_DRAIN
  } phase_t;

  // Configuration register map (word index = paddr[3:2])
  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_FIRST_HDR  = 2'd0;
  localparam logic [1:0] REG_SECOND_HDR = 2'd1;
  localparam logic [1:0] REG_MAX_LEN    = 2'd2;

  // Register reset values
  localparam logic [7:0] FIRST_HDR_RST  = 8'd170;
  localparam logic [7:0] SECOND_HDR_RST = 8'd85;
  localparam logic [6:0] MAX_LEN_RST    = 7'd64;

endpackage

`default_nettype wire

// ----- rtl/core/xcfd_byte_if.sv -----
// Byte channel carrying received link bytes into the deframer.
`default_nettype none

interface xcfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/xcfd_result_if.sv -----
// Result channel carrying one payload byte (or an empty-frame marker) per transaction.
`default_nettype none

interface xcfd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] topic;
  logic [6:0] frame_length;
  logic       has_data;
  logic [5:0] payload_index;
  logic [7:0] payload_value;
  logic       last;

  modport source (
    output valid, output topic, output frame_length, output has_data,
    output payload_index, output payload_value, output last, input ready
  );
  modport sink (
    input valid, input topic, input frame_length, input has_data,
    input payload_index, input payload_value, input last, output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/xor_checked_frame_deframer_unit.sv -----
// Top level of the header/length/XOR-checksum frame deframer.
//
//  channel   dir   payload                                   transaction when
//  rx_ch     in    rx_byte                                   valid & ready
//  res_ch    out   topic, frame_length, has_data,            valid & ready
//                  payload_index, payload_value, last
//  apb       in    first_header, second_header, max_length   psel & penable & pwrite
//
// rx_ch.ready is high except while a frame drains.
// A good checksum starts a drain of the payload buffer: one read per result through
// its single read port, then the output register; a new read waits until the last
// one has landed, and an empty frame gives 1 result. Stalls on res_ch stretch the drain.
// Synchronous reset clears control state; the buffer is not cleared (no clearing pass).
`default_nettype none

module xor_checked_frame_deframer_unit #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [xcfd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  xcfd_byte_if.sink                   rx_ch,
  xcfd_result_if.source               res_ch
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [6:0] MAX_LEN = 7'(MAX_PAYLOAD);

  // configuration registers
  logic [7:0] first_header;
  logic [7:0] second_header;
  logic [6:0] max_length;

  // parser state
  xcfd_pkg::phase_t phase, phase_next;
  logic [CW-1:0] fill_count;
  logic [7:0]    held_topic;
  logic [6:0]    held_length;
  logic [7:0]    running_xor;

  // drain state
  logic [AW-1:0] rd_idx;
  logic [AW-1:0] rd_idx_q;
  logic          rd_pend;
  logic          rd_last;
  logic [7:0]    rd_data;

  // output register
  logic       out_valid;
  logic [7:0] out_topic;
  logic [6:0] out_len;
  logic       out_has;
  logic [5:0] out_index;
  logic [7:0] out_value;
  logic       out_last;

  // control decode
  logic          rx_fire;
  logic [7:0]    b;
  logic [6:0]    limit;
  logic          len_ok;
  logic [CW-1:0] fill_inc;
  logic          out_free;
  logic          drain_last;
  logic          mem_we;
  logic          rd_issue;
  logic          empty_emit;
  logic          cfg_wr;

  // APB register file
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_header  <= xcfd_pkg::FIRST_HDR_RST;
      second_header <= xcfd_pkg::SECOND_HDR_RST;
      max_length    <= xcfd_pkg::MAX_LEN_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        xcfd_pkg::REG_FIRST_HDR:  first_header  <= pwdata[7:0];
        xcfd_pkg::REG_SECOND_HDR: second_header <= pwdata[7:0];
        xcfd_pkg::REG_MAX_LEN:    max_length    <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      xcfd_pkg::REG_FIRST_HDR:  prdata = {24'd0, first_header};
      xcfd_pkg::REG_SECOND_HDR: prdata = {24'd0, second_header};
      xcfd_pkg::REG_MAX_LEN:    prdata = {25'd0, max_length};
      default:                  prdata = 32'd0;
    endcase
  end

  // shared decode
  assign rx_fire    = rx_ch.valid & rx_ch.ready;
  assign b          = rx_ch.rx_byte;
  assign limit      = (max_length > MAX_LEN) ? MAX_LEN : max_length;
  assign len_ok     = (b <= {1'b0, limit});
  assign fill_inc   = fill_count + CW'(1);
  assign out_free   = !out_valid || res_ch.ready;
  assign drain_last = ((7'(rd_idx) + 7'd1) == held_length);

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      xcfd_pkg::PH_HDR1: begin
        if (rx_fire && b == first_header) phase_next = xcfd_pkg::PH_HDR2;
      end
      xcfd_pkg::PH_HDR2: begin
        if (rx_fire) begin
          phase_next = (b == second_header) ? xcfd_pkg::PH_TOPIC : xcfd_pkg::PH_HDR1;
        end
      end
      xcfd_pkg::PH_TOPIC: begin
        if (rx_fire) phase_next = xcfd_pkg::PH_LEN;
      end
      xcfd_pkg::PH_LEN: begin
        if (rx_fire) begin
          if (!len_ok) begin
            phase_next = xcfd_pkg::PH_HDR1;
          end else if (b == 8'd0) begin
            phase_next = xcfd_pkg::PH_SUM;
          end else begin
            phase_next = xcfd_pkg::PH_DATA;
          end
        end
      end
      xcfd_pkg::PH_DATA: begin
        if (rx_fire && 7'(fill_inc) >= held_length) phase_next = xcfd_pkg::PH_SUM;
      end
      xcfd_pkg::PH_SUM: begin
        if (rx_fire) begin
          phase_next = (b == running_xor) ? xcfd_pkg::PH_DRAIN : xcfd_pkg::PH_HDR1;
        end
      end
      xcfd_pkg::PH_DRAIN: begin
        if (empty_emit || (rd_issue && drain_last)) phase_next = xcfd_pkg::PH_HDR1;
      end
      default: phase_next = xcfd_pkg::PH_HDR1;
    endcase
  end

  // phase outputs
  always_comb begin
    rx_ch.ready = (phase != xcfd_pkg::PH_DRAIN);
    mem_we      = rx_fire && (phase == xcfd_pkg::PH_DATA);
    // a read goes out only when its data can land in the output register
    rd_issue    = (phase == xcfd_pkg::PH_DRAIN) && (held_length != 7'd0) &&
                  !rd_pend && out_free;
    empty_emit  = (phase == xcfd_pkg::PH_DRAIN) && (held_length == 7'd0) && out_free;
  end

  // parser and drain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= xcfd_pkg::PH_HDR1;
      fill_count  <= '0;
      held_topic  <= 8'd0;
      held_length <= 7'd0;
      running_xor <= 8'd0;
      rd_idx      <= '0;
      rd_pend     <= 1'b0;
    end else begin
      phase   <= phase_next;
      rd_pend <= rd_issue;
      if (rx_fire) begin
        case (phase)
          xcfd_pkg::PH_TOPIC: begin
            held_topic  <= b;
            running_xor <= b;
          end
          xcfd_pkg::PH_LEN: begin
            if (len_ok) begin
              held_length <= b[6:0];
              running_xor <= running_xor ^ b;
              fill_count  <= '0;
            end
          end
          xcfd_pkg::PH_DATA: begin
            running_xor <= running_xor ^ b;
            fill_count  <= fill_inc;
          end
          xcfd_pkg::PH_SUM: rd_idx <= '0;
          default: ;
        endcase
      end
      if (rd_issue) rd_idx <= rd_idx + AW'(1);
    end
  end

  // tag travelling with the read in flight
  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_idx_q <= rd_idx;
      rd_last  <= drain_last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_pend || empty_emit) begin
      out_valid <= 1'b1;
    end else if (res_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      out_topic <= held_topic;
      out_len   <= held_length;
      out_has   <= 1'b1;
      out_index <= 6'(rd_idx_q);
      out_value <= rd_data;
      out_last  <= rd_last;
    end else if (empty_emit) begin
      out_topic <= held_topic;
      out_len   <= held_length;
      out_has   <= 1'b0;
      out_index <= 6'd0;
      out_value <= 8'd0;
      out_last  <= 1'b1;
    end
  end

  assign res_ch.valid         = out_valid;
  assign res_ch.topic         = out_topic;
  assign res_ch.frame_length  = out_len;
  assign res_ch.has_data      = out_has;
  assign res_ch.payload_index = out_index;
  assign res_ch.payload_value = out_value;
  assign res_ch.last          = out_last;

  // payload buffer
  xcfd_payload_ram #(
    .DEPTH (MAX_PAYLOAD),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (fill_count[AW-1:0]),
    .wr_data (b),
    .rd_en   (rd_issue),
    .rd_addr (rd_idx),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

// ----- rtl/core/xcfd_payload_ram.sv -----
// Payload buffer: one write port, one read port, registered read data.
`default_nettype none

module xcfd_payload_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/xcfd_checker.sv -----
// Port-level checker for the deframer, with its bind to the top level.
`default_nettype none

module xcfd_checker (
  input logic       clk,
  input logic       rst,
  input logic       rx_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] res_topic,
  input logic [6:0] res_len,
  input logic       res_has_data,
  input logic [5:0] res_index,
  input logic [7:0] res_value,
  input logic       res_last
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid &&
      $stable({res_topic, res_len, res_has_data, res_index, res_value, res_last}))
    else $error("result changed while stalled");

  // input stays closed while a frame is still mid-drain
  a_mid_drain: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_last |-> !rx_ready)
    else $error("input accepted during drain");

  // empty frame marker
  a_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_has_data |-> res_last && res_index == 6'd0 &&
      res_len == 7'd0 && res_value == 8'd0)
    else $error("malformed empty-frame result");

  // payload index in range, last on the final byte only
  a_index: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_has_data |-> ({1'b0, res_index} < res_len) &&
      (res_last == (({1'b0, res_index} + 7'd1) == res_len)))
    else $error("payload index or last flag inconsistent");

endmodule

bind xor_checked_frame_deframer_unit xcfd_checker u_xcfd_checker (
  .clk          (clk),
  .rst          (rst),
  .rx_ready     (rx_ch.ready),
  .res_valid    (res_ch.valid),
  .res_ready    (res_ch.ready),
  .res_topic    (res_ch.topic),
  .res_len      (res_ch.frame_length),
  .res_has_data (res_ch.has_data),
  .res_index    (res_ch.payload_index),
  .res_value    (res_ch.payload_value),
  .res_last     (res_ch.last)
);

`default_nettype wire

// ----- dv/xcfd_frame_check.sv -----
// Frame predictor and result comparison for the XOR-checked frame deframer.
module xcfd_frame_check #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [xcfd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  xcfd_byte_if                        rx_ch,
  xcfd_result_if                      res_ch,
  output int unsigned                 fail_count,
  output int unsigned                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] topic;
    logic [6:0] frame_length;
    logic       has_data;
    logic [5:0] payload_index;
    logic [7:0] payload_value;
    logic       last;
  } frame_beat_t;

  // Register copies, tracked from APB writes
  logic [7:0] sync_first;
  logic [7:0] sync_second;
  logic [6:0] length_cap;

  // Parser state
  xcfd_pkg::phase_t parse_phase;
  logic [6:0] fill_count;
  logic [7:0] held_topic;
  logic [6:0] held_length;
  logic [7:0] running_xor;
  logic [7:0] payload_buf [MAX_PAYLOAD];

  frame_beat_t expected_beats[$];
  int unsigned mismatches = 0;

  assign fail_count = mismatches;

  function automatic int length_limit();
    return (int'(length_cap) > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(length_cap);
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Advance the parser by one received byte; queue the beats of a good frame
  task automatic parse_byte(input logic [7:0] b);
    frame_beat_t beat;
    case (parse_phase)
      xcfd_pkg::PH_HDR1: begin
        if (b == sync_first) parse_phase = xcfd_pkg::PH_HDR2;
      end
      xcfd_pkg::PH_HDR2: begin
        if (b == sync_second) parse_phase = xcfd_pkg::PH_TOPIC;
        else parse_phase = xcfd_pkg::PH_HDR1;
      end
      xcfd_pkg::PH_TOPIC: begin
        held_topic  = b;
        running_xor = b;
        parse_phase = xcfd_pkg::PH_LEN;
      end
      xcfd_pkg::PH_LEN: begin
        // full 8-bit length against the clamped limit
        if (int'(b) <= length_limit()) begin
          held_length = b[6:0];
          running_xor = running_xor ^ b;
          fill_count  = '0;
          if (b == 8'd0) parse_phase = xcfd_pkg::PH_SUM;
          else parse_phase = xcfd_pkg::PH_DATA;
        end else begin
          parse_phase = xcfd_pkg::PH_HDR1;
        end
      end
      xcfd_pkg::PH_DATA: begin
        payload_buf[int'(fill_count) % MAX_PAYLOAD] = b;
        running_xor = running_xor ^ b;
        fill_count  = fill_count + 7'd1;
        if (fill_count >= held_length) parse_phase = xcfd_pkg::PH_SUM;
      end
      default: begin
        parse_phase = xcfd_pkg::PH_HDR1;
        if (b == running_xor) begin
          beat.topic        = held_topic;
          beat.frame_length = held_length;
          if (held_length == 7'd0) begin
            // empty frame: one marker beat
            beat.has_data      = 1'b0;
            beat.payload_index = '0;
            beat.payload_value = '0;
            beat.last          = 1'b1;
            expected_beats.push_back(beat);
          end else begin
            for (int i = 0; i < int'(held_length); i++) begin
              beat.has_data      = 1'b1;
              beat.payload_index = 6'(i);
              beat.payload_value = payload_buf[i];
              beat.last          = (i + 1 == int'(held_length));
              expected_beats.push_back(beat);
            end
          end
        end
      end
    endcase
  endtask

  // Sample both channels and the config port at each edge
  always @(posedge clk) begin : watch
    frame_beat_t want;
    if (rst) begin
      sync_first  = xcfd_pkg::FIRST_HDR_RST;
      sync_second = xcfd_pkg::SECOND_HDR_RST;
      length_cap  = xcfd_pkg::MAX_LEN_RST;
      parse_phase = xcfd_pkg::PH_HDR1;
      fill_count  = '0;
      held_topic  = '0;
      held_length = '0;
      running_xor = '0;
      expected_beats.delete();
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected result transaction: topic %0d, index %0d, value %0d",
                 res_ch.topic, res_ch.payload_index, res_ch.payload_value);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          check_field("topic", want.topic, res_ch.topic);
          check_field("frame_length", want.frame_length, res_ch.frame_length);
          check_field("has_data", want.has_data, res_ch.has_data);
          check_field("payload_index", want.payload_index, res_ch.payload_index);
          check_field("payload_value", want.payload_value, res_ch.payload_value);
          check_field("last", want.last, res_ch.last);
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          xcfd_pkg::REG_FIRST_HDR:  sync_first  = pwdata[7:0];
          xcfd_pkg::REG_SECOND_HDR: sync_second = pwdata[7:0];
          xcfd_pkg::REG_MAX_LEN:    length_cap  = pwdata[6:0];
          default: ;
        endcase
      end
      if (rx_ch.valid && rx_ch.ready) parse_byte(rx_ch.rx_byte);
    end
    pending <= expected_beats.size();
  end

endmodule

// ----- dv/xor_checked_frame_deframer_unit_test.sv -----
// Stimulus, config sequencing and verdict for the XOR-checked frame deframer.
module xor_checked_frame_deframer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAYLOAD_DEPTH  = 64;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int PHASE_BYTES    = 25;

  logic                        clk     = 1'b0;
  logic                        rst     = 1'b1;
  logic                        psel    = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite  = 1'b0;
  logic [xcfd_pkg::ADDR_W-1:0] paddr   = '0;
  logic [31:0]                 pwdata  = '0;
  logic [31:0]                 prdata;
  logic                        pready;
  int unsigned                 fail_count;
  int unsigned                 pending;

  xcfd_byte_if   rx_ch();
  xcfd_result_if res_ch();

  // Config as last written, used to build frames
  logic [7:0] link_first  = xcfd_pkg::FIRST_HDR_RST;
  logic [7:0] link_second = xcfd_pkg::SECOND_HDR_RST;
  logic [6:0] link_cap    = xcfd_pkg::MAX_LEN_RST;

  bit          idle_on       = 1'b1;
  int unsigned hold_requests = 0;
  int unsigned bytes_offered = 0;

  // Reset-config opening: empty frame, 1-byte frame of all ones, repeated first
  // header, oversize length, bad checksum
  logic [7:0] opening_bytes [24] = '{
    8'hAA, 8'h55, 8'h00, 8'h00, 8'h00,
    8'hAA, 8'h55, 8'hFF, 8'h01, 8'hFF, 8'h01,
    8'hAA, 8'hAA, 8'h55,
    8'hAA, 8'h55, 8'h10, 8'h41,
    8'hAA, 8'h55, 8'h12, 8'h01, 8'h34, 8'h00
  };

  xor_checked_frame_deframer_unit #(.MAX_PAYLOAD(PAYLOAD_DEPTH)) uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rx_ch   (rx_ch),
    .res_ch  (res_ch)
  );

  xcfd_frame_check #(.MAX_PAYLOAD(PAYLOAD_DEPTH)) frame_check (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .rx_ch      (rx_ch),
    .res_ch     (res_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result sink: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int unsigned holds_served;
    holds_served = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && hold_requests != holds_served) begin
        holds_served = hold_requests;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_ch.ready <= 1'b1;
      end else if (rst || (idle_on && $urandom_range(99) < 12)) begin
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one byte, with an occasional gap first; returns at its transaction
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(99) < 12) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    bytes_offered++;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
  endtask

  task automatic send_frame(input logic [7:0] topic, input int len, input bit corrupt);
    logic [7:0] sum;
    logic [7:0] b;
    send_byte(link_first);
    send_byte(link_second);
    send_byte(topic);
    send_byte(8'(len));
    sum = topic ^ 8'(len);
    repeat (len) begin
      b = 8'($urandom);
      sum = sum ^ b;
      send_byte(b);
    end
    if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  // One random unit: mostly good frames, the rest broken sequences and noise
  task automatic send_random_unit(input bit full_length);
    int limit;
    int pick;
    int len;
    logic [7:0] b;
    limit = (int'(link_cap) > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : int'(link_cap);
    pick  = $urandom_range(99);
    if (full_length) begin
      send_frame(8'($urandom), limit, 1'b0);
    end else if (pick < 65) begin
      if (pick < 45) len = $urandom_range(0, (limit < 8) ? limit : 8);
      else len = $urandom_range(0, limit);
      send_frame(8'($urandom), len, 1'b0);
    end else if (pick < 75) begin
      send_frame(8'($urandom), $urandom_range(0, limit), 1'b1);
    end else if (pick < 82) begin
      // wrong second header
      send_byte(link_first);
      do b = 8'($urandom); while (b == link_second);
      send_byte(b);
    end else if (pick < 88) begin
      // length over the limit
      send_byte(link_first);
      send_byte(link_second);
      send_byte(8'($urandom));
      send_byte(8'($urandom_range(limit + 1, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  // Upper data bits are random; the registers keep only their own width
  task automatic apply_config(input logic [7:0] f, input logic [7:0] s, input logic [6:0] m);
    write_reg(xcfd_pkg::REG_FIRST_HDR, {24'($urandom), f});
    write_reg(xcfd_pkg::REG_SECOND_HDR, {24'($urandom), s});
    write_reg(xcfd_pkg::REG_MAX_LEN, {25'($urandom), m});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    link_first  = f;
    link_second = s;
    link_cap    = m;
  endtask

  // Stop offering and wait until every expected result has come, then settle
  task automatic wait_for_results();
    int guard;
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (pending != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned phase_start;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
    wait_for_results();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: apply_config(8'h00, 8'hFF, 7'd64);
        1: apply_config(8'hFF, 8'h00, 7'd0);
        2: apply_config(8'h5A, 8'h5A, 7'd127);
        3: apply_config(8'($urandom), 8'($urandom), 7'($urandom_range(1, 16)));
        default: apply_config(8'hAA, 8'h55, 7'd1);
      endcase
      // no idling on either side in one phase
      idle_on = (p != 2);
      // long receiver hold-off while bytes keep coming
      if (p == 3) hold_requests++;
      phase_start = bytes_offered;
      send_random_unit(1'b1);
      while (bytes_offered - phase_start < PHASE_BYTES) send_random_unit(1'b0);
      wait_for_results();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
